// ===== src/tag_id_inventory_counter_assert.svh =====
// Assertion macros shared by the inventory counter modules
`ifndef TAG_ID_INVENTORY_COUNTER_ASSERT_SVH
`define TAG_ID_INVENTORY_COUNTER_ASSERT_SVH

`ifndef SYNTH

// expression holds at every edge out of reset
`define TIDC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tidc assertion failed");

// consequent holds in the same cycle as the antecedent
`define TIDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tidc assertion failed");

// consequent holds in the cycle after the antecedent
`define TIDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tidc assertion failed");

`else

`define TIDC_ASSERT_ALWAYS(label, clk, rst, expr)
`define TIDC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TIDC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/tidc_pkg.sv =====
package tidc_pkg;

   // table sizing
   localparam int TABLE_ENTRIES = 128;
   localparam int COUNT_BITS    = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // field widths fixed by the transaction format
   localparam int ACTION_W = 2;
   localparam int ID_W     = 40;

   // queue between front and back
   localparam int Q_DEPTH  = 2;
   localparam int QPTR_W   = $clog2(Q_DEPTH);
   localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

   // action codes on the request
   localparam logic [ACTION_W-1:0] ACT_READ         = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_COUNTS = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_TABLE  = 2'd2;

   typedef enum logic [1:0] {
      OP_READ,
      OP_CLEAR_COUNTS,
      OP_CLEAR_TABLE,
      OP_IGNORE
   } op_kind_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_CLEAR
   } eng_state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     tag_id;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]      slot;
      logic [COUNT_BITS-1:0] read_count;
      logic                  is_new;
      logic                  dropped_full;
      logic [FILL_W-1:0]     entries_used;
   } rsp_type;

   // classified transaction held in the queue
   typedef struct packed {
      op_kind_type     kind;
      logic [ID_W-1:0] tag_id;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== src/tidc_front.sv =====
module tidc_front (
   input  logic                   start,
   input  tidc_pkg::req_type      req_data,
   input  tidc_pkg::q_status_type q_status,
   output logic                   busy,
   output tidc_pkg::push_type     push
);

   // hold requests off while the queue has no room
   assign busy = q_status.full;

   // decode the action into an operation kind
   always_comb begin
      push.valid       = start && !q_status.full;
      push.item.tag_id = req_data.tag_id;
      unique case (req_data.action)
         tidc_pkg::ACT_READ:         push.item.kind = tidc_pkg::OP_READ;
         tidc_pkg::ACT_CLEAR_COUNTS: push.item.kind = tidc_pkg::OP_CLEAR_COUNTS;
         tidc_pkg::ACT_CLEAR_TABLE:  push.item.kind = tidc_pkg::OP_CLEAR_TABLE;
         default:                    push.item.kind = tidc_pkg::OP_IGNORE;
      endcase
   end

endmodule

// ===== src/tidc_queue.sv =====
module tidc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tidc_pkg::push_type     push,
   input  logic                   pop,
   output tidc_pkg::item_type     head,
   output tidc_pkg::q_status_type q_status
);

   tidc_pkg::item_type              slot_ff [tidc_pkg::Q_DEPTH];
   logic [tidc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tidc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tidc_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign q_status.full  = (cnt_ff == tidc_pkg::QCNT_W'(tidc_pkg::Q_DEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign do_push = push.valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointer and occupancy update, wrapping at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tidc_pkg::QPTR_W'(tidc_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tidc_pkg::QPTR_W'(tidc_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ===== src/tidc_engine.sv =====
`include "tag_id_inventory_counter_assert.svh"

module tidc_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  tidc_pkg::item_type     head,
   input  tidc_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_strobe,
   output tidc_pkg::rsp_type      rsp_data
);

   // identifier and count memories, one read and one write port each
   logic [tidc_pkg::ID_W-1:0]       id_mem  [tidc_pkg::TABLE_ENTRIES];
   logic [tidc_pkg::COUNT_BITS-1:0] cnt_mem [tidc_pkg::TABLE_ENTRIES];

   tidc_pkg::eng_state_type         state_ff, state_in;
   logic [tidc_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [tidc_pkg::FILL_W-1:0]     idx_ff, idx_in;
   logic                            pend_ff, pend_in;
   logic [tidc_pkg::IDX_W-1:0]      pidx_ff, pidx_in;
   logic [tidc_pkg::ID_W-1:0]       tag_ff, tag_in;
   logic [tidc_pkg::ID_W-1:0]       id_rd_ff;
   logic [tidc_pkg::COUNT_BITS-1:0] cnt_rd_ff;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   tidc_pkg::rsp_type               rsp_ff, rsp_in;

   logic [tidc_pkg::IDX_W-1:0]      rd_addr, wr_addr;
   logic                            id_we, cnt_we;
   logic [tidc_pkg::COUNT_BITS-1:0] cnt_wdata, cnt_inc;
   logic                            issue, hit;

   assign issue   = (idx_ff < fill_ff);
   assign hit     = pend_ff && (id_rd_ff == tag_ff);
   assign cnt_inc = (cnt_rd_ff == tidc_pkg::COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // sequencer: scan filled entries one per cycle, sweep counts on clear
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      tag_in        = tag_ff;
      pop           = 1'b0;
      rd_addr       = idx_ff[tidc_pkg::IDX_W-1:0];
      wr_addr       = pidx_ff;
      id_we         = 1'b0;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.entries_used = fill_ff;
      unique case (state_ff)
         tidc_pkg::ENG_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               idx_in = '0;
               unique case (head.kind)
                  tidc_pkg::OP_READ: begin
                     tag_in   = head.tag_id;
                     state_in = tidc_pkg::ENG_SCAN;
                  end
                  tidc_pkg::OP_CLEAR_COUNTS: begin
                     state_in = tidc_pkg::ENG_CLEAR;
                  end
                  tidc_pkg::OP_CLEAR_TABLE: begin
                     fill_in             = '0;
                     rsp_strobe_in       = 1'b1;
                     rsp_in.entries_used = '0;
                  end
                  tidc_pkg::OP_IGNORE: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         tidc_pkg::ENG_SCAN: begin
            priority if (hit) begin
               // matched entry: bump its count
               cnt_we            = 1'b1;
               wr_addr           = pidx_ff;
               cnt_wdata         = cnt_inc;
               rsp_strobe_in     = 1'b1;
               rsp_in.slot       = pidx_ff;
               rsp_in.read_count = cnt_inc;
               state_in          = tidc_pkg::ENG_IDLE;
            end else if (issue) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
               pidx_in = idx_ff[tidc_pkg::IDX_W-1:0];
            end else if (!pend_ff) begin
               // no match among the filled entries
               rsp_strobe_in = 1'b1;
               state_in      = tidc_pkg::ENG_IDLE;
               if (fill_ff < tidc_pkg::FILL_W'(tidc_pkg::TABLE_ENTRIES)) begin
                  id_we               = 1'b1;
                  cnt_we              = 1'b1;
                  wr_addr             = fill_ff[tidc_pkg::IDX_W-1:0];
                  cnt_wdata           = tidc_pkg::COUNT_BITS'(1);
                  fill_in             = fill_ff + 1'b1;
                  rsp_in.slot         = fill_ff[tidc_pkg::IDX_W-1:0];
                  rsp_in.read_count   = tidc_pkg::COUNT_BITS'(1);
                  rsp_in.is_new       = 1'b1;
                  rsp_in.entries_used = fill_ff + 1'b1;
               end else begin
                  rsp_in.dropped_full = 1'b1;
               end
            end else begin
               // last read still in flight
            end
         end
         tidc_pkg::ENG_CLEAR: begin
            if (issue) begin
               cnt_we  = 1'b1;
               wr_addr = idx_ff[tidc_pkg::IDX_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = tidc_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = tidc_pkg::ENG_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tidc_pkg::ENG_IDLE;
         fill_ff       <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      tag_ff  <= tag_in;
      rsp_ff  <= rsp_in;
   end

   // memories with registered read
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[wr_addr] <= tag_ff;
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      id_rd_ff  <= id_mem[rd_addr];
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   `TIDC_ASSERT_ALWAYS(a_fill_range, clock, reset, fill_ff <= tidc_pkg::FILL_W'(tidc_pkg::TABLE_ENTRIES))
   `TIDC_ASSERT_IMPLY(a_pend_idx, clock, reset, pend_ff, (tidc_pkg::FILL_W'(pidx_ff) + 1'b1) == idx_ff)
   `TIDC_ASSERT_IMPLY(a_rsp_kind, clock, reset, rsp_strobe_ff, !(rsp_ff.is_new && rsp_ff.dropped_full))
   `TIDC_ASSERT_IMPLY(a_new_count, clock, reset, rsp_strobe_ff && rsp_ff.is_new, rsp_ff.read_count == tidc_pkg::COUNT_BITS'(1))
   `TIDC_ASSERT_NEXT(a_hit_rsp, clock, reset, (state_ff == tidc_pkg::ENG_SCAN) && hit, rsp_strobe_ff && (rsp_ff.slot == $past(pidx_ff)))

endmodule

// ===== src/tag_id_inventory_counter.sv =====
// Tag identifier inventory: a table of seen 40-bit tag IDs with a read count each.
// Request channel: req_data (action, tag_id) is taken at a clock edge with start
// high and busy low. A two-entry queue sits behind the request port, so busy is
// raised only while that queue is full.
// Result channel: every transaction gives exactly one result on rsp_data, shown
// for one cycle with rsp_strobe high. The receiver cannot stall; results are never
// held back.
// Steps: a read scans the filled entries in order and stops at the first match; a
// new tag is appended at the fill level, or dropped when the table is full; clear
// counts sweeps the filled entries back to zero; clear table and the unused action
// answer straight from idle. The back end scans the identifier memory one entry per
// cycle through its single read port.
// One transaction is worked on at a time; up to two more wait in the queue.
// Reset (synchronous, active high) empties the queue and the table at once; no
// clearing pass runs, since entries past the fill level are never read.
module tag_id_inventory_counter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tidc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tidc_pkg::rsp_type rsp_data
);

   tidc_pkg::push_type     push;
   tidc_pkg::q_status_type q_status;
   tidc_pkg::item_type     head;
   logic                   pop;

   // accept and classify
   tidc_front u_front (
      .start    (start),
      .req_data (req_data),
      .q_status (q_status),
      .busy     (busy),
      .push     (push)
   );

   // decoupling queue
   tidc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // table search and update
   tidc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
